### hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 6;
  // slot numbers and counts up to the largest supported capacity
  localparam int unsigned SlotW   = 7;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_PREPEND = 3'd1,
    MODE_INSERT  = 3'd2,
    MODE_READ    = 3'd3,
    MODE_UPDATE  = 3'd4,
    MODE_DEL_FST = 3'd5,
    MODE_DEL_LST = 3'd6,
    MODE_DEL_POS = 3'd7
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] tail;
  } cell_cmd_t;

endpackage

### hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds an element and shifts with its neighbours
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
(
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [SlotW-1:0] idx_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  input  logic [DataW-1:0] value_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_OPEN: begin
        if (idx_i > cmd_i.slot) begin
          data_d = left_i;
        end else if (idx_i == cmd_i.slot) begin
          data_d = value_i;
        end
      end
      CELL_CLOSE: begin
        if (idx_i >= cmd_i.slot) begin
          data_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (idx_i == cmd_i.slot) begin
          data_d = value_i;
        end
      end
      CELL_ROTATE: begin
        if (idx_i < cmd_i.tail) begin
          data_d = right_i;
        end else if (idx_i == cmd_i.tail) begin
          data_d = value_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// ordered list of signed 32-bit values held in a chain of shifting cells
// ----------------------------------------------------------------------------
// single-result operations give their result in the cycle after the transfer
// read all: the first element passes through the read state and the output register,
// then one element per cycle while the output is free; throughput: one edit per cycle
// while the output is free; the next item can transfer with the last result
// reset: asynchronous, clears element count and control; cell contents undefined
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[37:32], zero fill
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // element[31:0], index[37:32], count[43:38], zero fill
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_q, rd_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [DataW-1:0] out_elem_q, out_elem_d;
  logic [PosW-1:0]  out_index_q, out_index_d;
  logic [PosW-1:0]  out_count_q, out_count_d;
  logic             out_last_q, out_last_d;

  cell_cmd_t        cmd;
  logic [DataW-1:0] cell_val;
  logic [DataW-1:0] cell_data [CAPACITY];

  logic             out_free;
  logic             in_fire;
  logic             emit;
  logic             full;
  logic             empty;
  logic             pos_zero;
  logic [CmpW-1:0]  pos_w;
  logic [CmpW-1:0]  cnt_w;
  logic [SlotW-1:0] pos_slot;
  logic [SlotW-1:0] tail_slot;
  logic [DataW-1:0] in_value;
  logic [PosW-1:0]  in_pos;
  mode_e            in_mode;
  status_e          st;
  logic             rd_last;

  assign in_value  = s_axis_tdata[31:0];
  assign in_pos    = s_axis_tdata[37:32];
  assign in_mode   = mode_e'(s_axis_tuser);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign full      = (count_q == CntW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign pos_zero  = (in_pos == '0);
  assign pos_w     = CmpW'(in_pos);
  assign cnt_w     = CmpW'(count_q);
  assign pos_slot  = SlotW'(in_pos) - SlotW'(1);
  assign tail_slot = SlotW'(count_q) - SlotW'(1);
  assign rd_last   = (rd_q == count_q - CntW'(1));
  assign cell_val  = (state_q == ST_READ) ? cell_data[0] : in_value;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_d         = rd_q;
    cmd.op       = CELL_HOLD;
    cmd.slot     = '0;
    cmd.tail     = tail_slot;
    emit         = 1'b0;
    st           = STATUS_OK;
    out_elem_d   = '0;
    out_index_d  = '0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          emit = 1'b1;
          case (in_mode)
            MODE_APPEND, MODE_PREPEND: begin
              if (full) begin
                st = STATUS_FULL;
              end else begin
                cmd.op   = CELL_OPEN;
                cmd.slot = (in_mode == MODE_APPEND) ? SlotW'(count_q) : '0;
                count_d  = count_q + CntW'(1);
              end
            end
            MODE_INSERT: begin
              if (pos_zero || pos_w > cnt_w + CmpW'(1)) begin
                st = STATUS_BADPOS;
              end else if (full) begin
                st = STATUS_FULL;
              end else begin
                cmd.op   = CELL_OPEN;
                cmd.slot = pos_slot;
                count_d  = count_q + CntW'(1);
              end
            end
            MODE_READ: begin
              if (empty) begin
                st = STATUS_EMPTY;
              end else begin
                emit    = 1'b0;
                state_d = ST_READ;
                rd_d    = '0;
              end
            end
            MODE_UPDATE: begin
              if (pos_zero || pos_w > cnt_w) begin
                st = STATUS_BADPOS;
              end else begin
                cmd.op   = CELL_WRITE;
                cmd.slot = pos_slot;
              end
            end
            MODE_DEL_FST, MODE_DEL_LST: begin
              if (empty) begin
                st = STATUS_EMPTY;
              end else begin
                cmd.op   = CELL_CLOSE;
                cmd.slot = (in_mode == MODE_DEL_FST) ? '0 : tail_slot;
                count_d  = count_q - CntW'(1);
              end
            end
            MODE_DEL_POS: begin
              if (empty) begin
                st = STATUS_EMPTY;
              end else if (pos_zero || pos_w > cnt_w) begin
                st = STATUS_BADPOS;
              end else begin
                cmd.op   = CELL_CLOSE;
                cmd.slot = pos_slot;
                count_d  = count_q - CntW'(1);
              end
            end
            default: st = STATUS_OK;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit        = 1'b1;
          cmd.op      = CELL_ROTATE;
          out_elem_d  = cell_data[0];
          out_index_d = PosW'(rd_q + CntW'(1));
          out_last_d  = rd_last;
          rd_d        = rd_q + CntW'(1);
          if (rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_status_d = st;
    out_count_d  = PosW'(count_d);
    out_valid_d  = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (SlotW'(i)),
      .left_i  (left),
      .right_i (right),
      .value_i (cell_val),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= out_status_d;
      out_elem_q   <= out_elem_d;
      out_index_q  <= out_index_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0, out_count_q, out_index_q, out_elem_q};

`ifndef ASSERT_OFF
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_read_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> count_q != '0)
    else $error("read all running on an empty list");

  a_edit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_mode != MODE_READ) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("edit transfer gave no single result");

  a_read_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> $stable(count_q))
    else $error("count changed during read all");
`endif

endmodule
